// ----- rtl/core/mic_pkg.sv -----
`default_nettype none

package mic_pkg;

  // Table size and derived widths
  localparam int ENTRIES  = 16;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SUM_W    = 32 + IDX_W + 1;
  localparam int DIFF_W   = SUM_W + 1;
  localparam int MISM_MAX = (ENTRIES < 31) ? ENTRIES : 31;

  // Item opcodes
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  // One stored interference entry, as held in the table RAM
  typedef struct packed {
    logic signed [31:0] vz;
    logic signed [31:0] vy;
    logic signed [31:0] vx;
    logic [7:0]         frame;
    logic [47:0]        life;
    logic [47:0]        stamp;
  } entry_t;

  // Control from the sequencer to the accumulator
  typedef struct packed {
    logic clear;
    logic step;
    logic live;
  } acc_ctl_t;

  localparam logic signed [DIFF_W-1:0] SAT_MAX = DIFF_W'(64'sd2147483647);
  localparam logic signed [DIFF_W-1:0] SAT_MIN = DIFF_W'(-64'sd2147483648);

  // Clamp a difference to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [DIFF_W-1:0] d);
    logic signed [31:0] r;
    if (d > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (d < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = d[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mic_req_if.sv -----
`default_nettype none

interface mic_req_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [3:0]         source_index;
  logic [7:0]         frame_tag;
  logic [47:0]        stamp;
  logic [47:0]        lifetime;
  logic signed [31:0] field_x;
  logic signed [31:0] field_y;
  logic signed [31:0] field_z;

  modport source (
    output valid, opcode, source_index, frame_tag, stamp, lifetime,
           field_x, field_y, field_z,
    input  ready
  );

  modport sink (
    input  valid, opcode, source_index, frame_tag, stamp, lifetime,
           field_x, field_y, field_z,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/mic_rsp_if.sv -----
`default_nettype none

interface mic_rsp_if;
  logic               valid;
  logic               ready;
  logic [7:0]         out_frame_tag;
  logic [47:0]        out_stamp;
  logic signed [31:0] corrected_x;
  logic signed [31:0] corrected_y;
  logic signed [31:0] corrected_z;
  logic [4:0]         mismatched_entries;

  modport source (
    output valid, out_frame_tag, out_stamp, corrected_x, corrected_y,
           corrected_z, mismatched_entries,
    input  ready
  );

  modport sink (
    input  valid, out_frame_tag, out_stamp, corrected_x, corrected_y,
           corrected_z, mismatched_entries,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/mic_ram.sv -----
`default_nettype none

// Single-port-write, single-port-read RAM with registered read data
module mic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/mic_accum.sv -----
`default_nettype none

// Per-entry accumulator: one table entry per step
module mic_accum (
  input  logic                          clk,
  input  mic_pkg::acc_ctl_t             ctl,
  input  mic_pkg::entry_t               ent,
  input  logic [7:0]                    frame,
  input  logic [47:0]                   stamp,
  output logic signed [mic_pkg::SUM_W-1:0] sum_x,
  output logic signed [mic_pkg::SUM_W-1:0] sum_y,
  output logic signed [mic_pkg::SUM_W-1:0] sum_z,
  output logic [4:0]                    mism
);

  logic [48:0] expiry;
  logic        alive;
  logic        same_frame;

  // Entry is live while stamp + lifetime has not fallen below the sample time
  assign expiry     = {1'b0, ent.stamp} + {1'b0, ent.life};
  assign alive      = ctl.live && (expiry >= {1'b0, stamp});
  assign same_frame = (ent.frame == frame);

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      sum_x <= '0;
      sum_y <= '0;
      sum_z <= '0;
      mism  <= '0;
    end else if (ctl.step && alive) begin
      if (same_frame) begin
        sum_x <= sum_x + mic_pkg::SUM_W'(ent.vx);
        sum_y <= sum_y + mic_pkg::SUM_W'(ent.vy);
        sum_z <= sum_z + mic_pkg::SUM_W'(ent.vz);
      end else if (mism != 5'd31) begin
        mism <= mism + 5'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/magnetic_interference_compensator.sv -----
`default_nettype none

// Channel  Modport        Items carried
// -------  -------------  ---------------------------------------------------
// req      mic_req_if     field updates (opcode 0) and magnetometer samples
// rsp      mic_rsp_if     corrected samples, one per sample item
//
// An update does a table RAM read, then a conditional write-back.
// A sample sweeps the table, reading one RAM entry per cycle through the
// accumulator; then the finish state saturates and loads rsp.
// Reset clears the valid bits at once; the RAM itself is not cleared.
// A new item is taken while a result waits on rsp; a sample that finishes
// before rsp is free holds in its last cycle until rsp is taken.
module magnetic_interference_compensator (
  input  logic       clk,
  input  logic       rst,
  mic_req_if.sink    req,
  mic_rsp_if.source  rsp
);

  localparam logic [mic_pkg::IDX_W-1:0] LAST = mic_pkg::IDX_W'(mic_pkg::ENTRIES - 1);

  mic_pkg::state_t              state, state_next;
  logic [mic_pkg::IDX_W-1:0]    cnt, cnt_next;
  logic [mic_pkg::ENTRIES-1:0]  entry_valid;

  // Latched item
  logic [mic_pkg::IDX_W-1:0]    lat_idx;
  logic                         lat_idx_ok;
  logic [7:0]                   lat_frame;
  logic [47:0]                  lat_stamp;
  logic [47:0]                  lat_life;
  logic signed [31:0]           lat_vx, lat_vy, lat_vz;

  logic                         accept;
  logic                         load;
  logic                         keep_old;
  logic                         ram_we;
  logic [mic_pkg::IDX_W-1:0]    ram_raddr;
  mic_pkg::entry_t              ram_wdata;
  mic_pkg::entry_t              ram_rdata;
  mic_pkg::acc_ctl_t            acc_ctl;

  logic signed [mic_pkg::SUM_W-1:0] sum_x, sum_y, sum_z;
  logic [4:0]                   mism;

  // Output register
  logic                         out_valid;
  logic [7:0]                   out_frame;
  logic [47:0]                  out_stamp;
  logic signed [31:0]           out_x, out_y, out_z;
  logic [4:0]                   out_mism;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == mic_pkg::ST_IDLE);

  // Table read address: the update's entry or entry 0 on accept, next entry in sweep
  assign ram_raddr = (state == mic_pkg::ST_IDLE)
                   ? ((req.opcode == mic_pkg::OP_SAMPLE) ? '0
                                                         : mic_pkg::IDX_W'(req.source_index))
                   : cnt + 1'b1;

  // Skip the write when the stored entry is valid and strictly newer
  assign keep_old = entry_valid[lat_idx] && (lat_stamp < ram_rdata.stamp);
  assign ram_we   = (state == mic_pkg::ST_UPD) && lat_idx_ok && !keep_old;

  assign ram_wdata.stamp = lat_stamp;
  assign ram_wdata.life  = lat_life;
  assign ram_wdata.frame = lat_frame;
  assign ram_wdata.vx    = lat_vx;
  assign ram_wdata.vy    = lat_vy;
  assign ram_wdata.vz    = lat_vz;

  mic_ram #(
    .WIDTH ($bits(mic_pkg::entry_t)),
    .DEPTH (mic_pkg::ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (lat_idx),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign acc_ctl.clear = accept && (req.opcode == mic_pkg::OP_SAMPLE);
  assign acc_ctl.step  = (state == mic_pkg::ST_SWEEP);
  assign acc_ctl.live  = entry_valid[cnt];

  mic_accum u_accum (
    .clk   (clk),
    .ctl   (acc_ctl),
    .ent   (ram_rdata),
    .frame (lat_frame),
    .stamp (lat_stamp),
    .sum_x (sum_x),
    .sum_y (sum_y),
    .sum_z (sum_z),
    .mism  (mism)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mic_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    load       = 1'b0;
    case (state)
      mic_pkg::ST_IDLE: begin
        cnt_next = '0;
        if (accept) begin
          state_next = (req.opcode == mic_pkg::OP_SAMPLE) ? mic_pkg::ST_SWEEP
                                                          : mic_pkg::ST_UPD;
        end
      end
      mic_pkg::ST_UPD: begin
        state_next = mic_pkg::ST_IDLE;
      end
      mic_pkg::ST_SWEEP: begin
        if (cnt == LAST) begin
          state_next = mic_pkg::ST_FINISH;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      mic_pkg::ST_FINISH: begin
        if (!out_valid || rsp.ready) begin
          load       = 1'b1;
          state_next = mic_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mic_pkg::ST_IDLE;
      end
    endcase
  end

  // Item latch
  always_ff @(posedge clk) begin
    if (accept) begin
      lat_idx    <= mic_pkg::IDX_W'(req.source_index);
      lat_idx_ok <= (32'(req.source_index) < mic_pkg::ENTRIES);
      lat_frame  <= req.frame_tag;
      lat_stamp  <= req.stamp;
      lat_life   <= req.lifetime;
      lat_vx     <= req.field_x;
      lat_vy     <= req.field_y;
      lat_vz     <= req.field_z;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (ram_we) begin
      entry_valid[lat_idx] <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_frame <= lat_frame;
      out_stamp <= lat_stamp;
      out_x     <= mic_pkg::sat32(mic_pkg::DIFF_W'(lat_vx) - mic_pkg::DIFF_W'(sum_x));
      out_y     <= mic_pkg::sat32(mic_pkg::DIFF_W'(lat_vy) - mic_pkg::DIFF_W'(sum_y));
      out_z     <= mic_pkg::sat32(mic_pkg::DIFF_W'(lat_vz) - mic_pkg::DIFF_W'(sum_z));
      out_mism  <= mism;
    end
  end

  assign rsp.valid              = out_valid;
  assign rsp.out_frame_tag      = out_frame;
  assign rsp.out_stamp          = out_stamp;
  assign rsp.corrected_x        = out_x;
  assign rsp.corrected_y        = out_y;
  assign rsp.corrected_z        = out_z;
  assign rsp.mismatched_entries = out_mism;

  // A sample starts its sweep at entry 0
  a_sweep_start: assert property (@(posedge clk) disable iff (rst)
    (accept && req.opcode == mic_pkg::OP_SAMPLE)
      |=> (state == mic_pkg::ST_SWEEP && cnt == '0))
    else $error("sample did not start sweep at entry 0");

  // An update never produces a result
  a_update_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && req.opcode == mic_pkg::OP_UPDATE && !out_valid) |=> !out_valid)
    else $error("update produced a result");

  // A table write leaves that entry marked valid
  a_write_marks_valid: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> entry_valid[$past(lat_idx)])
    else $error("written entry not marked valid");

  // Mismatch count bounded by the table size
  a_mism_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(out_mism) <= mic_pkg::MISM_MAX))
    else $error("mismatch count exceeds table size");

endmodule

`default_nettype wire

// ----- sim/tb_magnetic_interference_compensator.sv -----
module tb_magnetic_interference_compensator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1720;
  localparam int TAIL_START   = 1500;
  localparam int QUIET_LIMIT  = 3000;
  localparam int LONG_HOLD    = 400;

  localparam logic [47:0] STAMP_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic signed [31:0] NT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] NT_MIN = 32'sh8000_0000;

  typedef struct {
    logic               op;
    logic [3:0]         idx;
    logic [7:0]         frame;
    logic [47:0]        stamp;
    logic [47:0]        life;
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
    bit                 wait_drain;
  } field_item_t;

  typedef struct {
    logic [7:0]         frame;
    logic [47:0]        stamp;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [4:0]         miss;
  } corrected_t;

  logic clk;
  logic rst;

  mic_req_if req ();
  mic_rsp_if rsp ();

  magnetic_interference_compensator i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Interference table as the block should hold it
  logic               src_valid [mic_pkg::ENTRIES];
  logic [47:0]        src_stamp [mic_pkg::ENTRIES];
  logic [47:0]        src_life  [mic_pkg::ENTRIES];
  logic [7:0]         src_frame [mic_pkg::ENTRIES];
  logic signed [31:0] src_vx    [mic_pkg::ENTRIES];
  logic signed [31:0] src_vy    [mic_pkg::ENTRIES];
  logic signed [31:0] src_vz    [mic_pkg::ENTRIES];

  field_item_t pending_items[$];
  corrected_t  expected_corrections[$];

  int items_taken;
  int results_seen;
  int mismatch_cnt;
  int stale_skips;
  int expired_hits;
  int mismatch_frames;

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic signed [31:0] clamp_nt(input longint d);
    if (d > 64'sd2147483647) begin
      return NT_MAX;
    end
    if (d < -64'sd2147483648) begin
      return NT_MIN;
    end
    return d[31:0];
  endfunction

  // Idling is off in one mid-run window and in the tail of the run
  function automatic bit quiet_stretch(input int n);
    return (n >= 600 && n < 750) || n >= TAIL_START;
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  // Mostly moderate field values, now and then the full 32-bit range
  function automatic logic signed [31:0] pick_nt();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom;
    end
    return int'($urandom_range(0, 200000)) - 100000;
  endfunction

  // Table update or compensation of one accepted item
  task automatic compensate_item(input field_item_t it);
    longint      acc_x;
    longint      acc_y;
    longint      acc_z;
    int          miss;
    logic [48:0] expiry;
    corrected_t  res;
    if (it.op == mic_pkg::OP_UPDATE) begin
      if (it.idx < mic_pkg::ENTRIES) begin
        if (src_valid[it.idx] && it.stamp < src_stamp[it.idx]) begin
          stale_skips++;
        end else begin
          src_valid[it.idx] = 1'b1;
          src_stamp[it.idx] = it.stamp;
          src_life[it.idx]  = it.life;
          src_frame[it.idx] = it.frame;
          src_vx[it.idx]    = it.fx;
          src_vy[it.idx]    = it.fy;
          src_vz[it.idx]    = it.fz;
        end
      end
    end else begin
      acc_x = 0;
      acc_y = 0;
      acc_z = 0;
      miss  = 0;
      for (int i = 0; i < mic_pkg::ENTRIES; i++) begin
        if (src_valid[i]) begin
          // exact 49-bit expiry, live while not below the sample's stamp
          expiry = {1'b0, src_stamp[i]} + {1'b0, src_life[i]};
          if (expiry < {1'b0, it.stamp}) begin
            expired_hits++;
          end else if (src_frame[i] != it.frame) begin
            if (miss < 31) begin
              miss++;
            end
          end else begin
            acc_x += src_vx[i];
            acc_y += src_vy[i];
            acc_z += src_vz[i];
          end
        end
      end
      if (miss != 0) begin
        mismatch_frames++;
      end
      res.frame = it.frame;
      res.stamp = it.stamp;
      res.cx    = clamp_nt(longint'(it.fx) - acc_x);
      res.cy    = clamp_nt(longint'(it.fy) - acc_y);
      res.cz    = clamp_nt(longint'(it.fz) - acc_z);
      res.miss  = 5'(miss);
      expected_corrections.push_back(res);
    end
  endtask

  task automatic push_update(input logic [3:0] idx, input logic [7:0] frame,
                             input logic [47:0] st, input logic [47:0] life,
                             input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic signed [31:0] z, input bit drain = 1'b0);
    field_item_t it;
    it.op = mic_pkg::OP_UPDATE;
    it.idx = idx;
    it.frame = frame;
    it.stamp = st;
    it.life = life;
    it.fx = x;
    it.fy = y;
    it.fz = z;
    it.wait_drain = drain;
    pending_items.push_back(it);
  endtask

  // Source index and lifetime are unused on samples, so they carry noise
  task automatic push_sample(input logic [7:0] frame, input logic [47:0] st,
                             input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic signed [31:0] z, input bit drain = 1'b0);
    field_item_t it;
    it.op = mic_pkg::OP_SAMPLE;
    it.idx = 4'($urandom);
    it.frame = frame;
    it.stamp = st;
    it.life = rand48();
    it.fx = x;
    it.fy = y;
    it.fz = z;
    it.wait_drain = drain;
    pending_items.push_back(it);
  endtask

  // Request driver
  field_item_t drv_item;
  int          src_gap;

  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (req.valid && req.ready) begin
        compensate_item(drv_item);
        items_taken++;
        if (!quiet_stretch(items_taken) && $urandom_range(0, 5) == 0) begin
          src_gap = $urandom_range(1, 17);
        end
      end
      if (req.valid && !req.ready) begin
        // item still on offer
      end else if (src_gap > 0) begin
        src_gap--;
        req.valid <= 1'b0;
      end else if (pending_items.size() != 0 &&
                   !(pending_items[0].wait_drain && expected_corrections.size() != 0)) begin
        drv_item = pending_items.pop_front();
        req.opcode       <= drv_item.op;
        req.source_index <= drv_item.idx;
        req.frame_tag    <= drv_item.frame;
        req.stamp        <= drv_item.stamp;
        req.lifetime     <= drv_item.life;
        req.field_x      <= drv_item.fx;
        req.field_y      <= drv_item.fy;
        req.field_z      <= drv_item.fz;
        req.valid        <= 1'b1;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver stalls
  int snk_gap;
  int long_hold;

  always @(posedge clk) begin
    corrected_t exp_res;
    if (rst) begin
      rsp.ready <= 1'b0;
      snk_gap = 0;
      long_hold = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        results_seen++;
        if (expected_corrections.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected result frame %0d stamp %0d", $time,
                   rsp.out_frame_tag, rsp.out_stamp);
        end else begin
          exp_res = expected_corrections.pop_front();
          if (rsp.out_frame_tag !== exp_res.frame) begin
            mismatch_cnt++;
            $display("%0t: out_frame_tag expected %0d actual %0d", $time,
                     exp_res.frame, rsp.out_frame_tag);
          end
          if (rsp.out_stamp !== exp_res.stamp) begin
            mismatch_cnt++;
            $display("%0t: out_stamp expected %0d actual %0d", $time,
                     exp_res.stamp, rsp.out_stamp);
          end
          if (rsp.corrected_x !== exp_res.cx) begin
            mismatch_cnt++;
            $display("%0t: corrected_x expected %0d actual %0d", $time,
                     exp_res.cx, rsp.corrected_x);
          end
          if (rsp.corrected_y !== exp_res.cy) begin
            mismatch_cnt++;
            $display("%0t: corrected_y expected %0d actual %0d", $time,
                     exp_res.cy, rsp.corrected_y);
          end
          if (rsp.corrected_z !== exp_res.cz) begin
            mismatch_cnt++;
            $display("%0t: corrected_z expected %0d actual %0d", $time,
                     exp_res.cz, rsp.corrected_z);
          end
          if (rsp.mismatched_entries !== exp_res.miss) begin
            mismatch_cnt++;
            $display("%0t: mismatched_entries expected %0d actual %0d", $time,
                     exp_res.miss, rsp.mismatched_entries);
          end
        end
        // one long back-pressure episode so the block fills and stalls req
        if (results_seen == 300) begin
          long_hold = LONG_HOLD;
        end
      end
      if (long_hold > 0) begin
        long_hold--;
        rsp.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        rsp.ready <= 1'b0;
      end else if (rsp.ready && !quiet_stretch(items_taken) &&
                   $urandom_range(0, 5) == 0) begin
        snk_gap = $urandom_range(1, 17) - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles with no item moving on either channel
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    logic [47:0]        now;
    logic [47:0]        st;
    logic [47:0]        life;
    logic [7:0]         frame;
    logic [7:0]         frame_pool [4];
    int                 off;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;

    rst = 1'b1;
    req.valid = 1'b0;
    req.opcode = mic_pkg::OP_UPDATE;
    req.source_index = '0;
    req.frame_tag = '0;
    req.stamp = '0;
    req.lifetime = '0;
    req.field_x = '0;
    req.field_y = '0;
    req.field_z = '0;
    rsp.ready = 1'b0;
    for (int i = 0; i < mic_pkg::ENTRIES; i++) begin
      src_valid[i] = 1'b0;
    end

    // Empty table: sample passes through unchanged
    push_sample(8'd0, 48'd0, NT_MAX, NT_MIN, 32'sd0);
    push_update(4'd0, 8'd5, 48'd100, 48'd50, 32'sd1000, -32'sd2000, 32'sd3000);
    push_update(4'd15, 8'd5, 48'd100, 48'd0, NT_MIN, NT_MAX, 32'sd7);
    // saturation high on x, low on y
    push_sample(8'd5, 48'd100, NT_MAX, NT_MIN, 32'sd0);
    // stamp + lifetime equal to the sample's stamp is still live
    push_sample(8'd5, 48'd150, 32'sd0, 32'sd0, 32'sd0);
    push_sample(8'd5, 48'd151, 32'sd5, -32'sd5, 32'sd0);
    // live entry in another frame is counted, not subtracted
    push_sample(8'd9, 48'd120, 32'sd10, 32'sd20, 32'sd30);
    // older update is dropped, equal stamp overwrites
    push_update(4'd0, 8'd9, 48'd99, 48'd50, 32'sd11, 32'sd22, 32'sd33);
    push_update(4'd0, 8'd9, 48'd100, 48'd50, 32'sd1, 32'sd2, 32'sd3);
    push_sample(8'd9, 48'd120, 32'sd10, 32'sd20, 32'sd30);
    // every entry live forever, 49-bit expiry sum
    for (int i = 0; i < mic_pkg::ENTRIES; i++) begin
      push_update(4'(i), 8'd3, STAMP_MAX, STAMP_MAX, NT_MAX, NT_MIN, pick_nt());
    end
    push_sample(8'hFF, STAMP_MAX, 32'sd0, 32'sd0, 32'sd0);
    push_sample(8'd3, STAMP_MAX, NT_MIN, NT_MAX, 32'sd0);
    push_sample(8'd3, 48'd0, NT_MIN, NT_MAX, NT_MIN);

    // Random traffic around a moving time base, table cleared by fresh reset
    // state is not assumed: old entries from the directed part stay in play
    for (int i = 0; i < 4; i++) begin
      frame_pool[i] = 8'($urandom);
    end
    now = 48'd1000;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 99) == 0) begin
        now = rand48();
      end else begin
        now = now + 48'($urandom_range(0, 20));
      end
      frame = ($urandom_range(0, 9) == 0) ? 8'($urandom) : frame_pool[$urandom_range(0, 3)];
      x = pick_nt();
      y = pick_nt();
      z = pick_nt();
      if ($urandom_range(0, 99) < 45) begin
        off = $urandom_range(0, 30);
        st = (now >= 48'(off)) ? now - 48'(off) : now;
        case ($urandom_range(0, 19))
          0, 1: begin
            life = rand48();
          end
          2: begin
            life = '0;
          end
          default: begin
            life = 48'($urandom_range(0, 600));
          end
        endcase
        push_update(4'($urandom), frame, st, life, x, y, z, n % 400 == 399);
      end else begin
        push_sample(frame, now, x, y, z, n % 400 == 399);
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || req.valid) begin
      @(posedge clk);
    end
    while (expected_corrections.size() != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);

    $display("items %0d, corrected samples %0d, stale updates dropped %0d",
             items_taken, results_seen, stale_skips);
    $display("expired entries skipped %0d, samples with foreign-frame entries %0d",
             expired_hits, mismatch_frames);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
